@@ hw/rtl/cwst_pkg.sv @@
// ----------------------------------------------------------------------------
// cwst_pkg
// Shared types and codes for the coalescing work slot table.
// ----------------------------------------------------------------------------
package cwst_pkg;

    // Request kinds carried on the input tuser
    localparam logic [1:0] ACT_SCHEDULE = 2'd0;
    localparam logic [1:0] ACT_TAKE     = 2'd1;
    localparam logic [1:0] ACT_STATUS   = 2'd2;

    // Result codes carried on the output tuser
    localparam logic [2:0] RES_SCHEDULED = 3'd0;
    localparam logic [2:0] RES_COALESCED = 3'd1;
    localparam logic [2:0] RES_DROPPED   = 3'd2;
    localparam logic [2:0] RES_REFUSED   = 3'd3;
    localparam logic [2:0] RES_TAKEN     = 3'd4;
    localparam logic [2:0] RES_EMPTY     = 3'd5;
    localparam logic [2:0] RES_STATUS    = 3'd6;

    // Fixed field widths
    localparam int HANDLER_W = 16;
    localparam int TAG_W     = 32;
    localparam int COUNT_W   = 5;
    localparam int TOTAL_W   = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    // Operation latched at accept
    typedef enum logic [1:0] {
        OP_SCHED  = 2'd0,
        OP_TAKE   = 2'd1,
        OP_STAT   = 2'd2,
        OP_REFUSE = 2'd3
    } op_t;

endpackage

@@ hw/rtl/coalescing_work_slot_table.sv @@
// ----------------------------------------------------------------------------
// coalescing_work_slot_table
// Table of work slots with duplicate merging, lowest-first take and counters.
// ----------------------------------------------------------------------------
// Each input beat is one request: schedule (tuser 0), take (tuser 1) or
// status (tuser 2 or 3). One request is in flight at a time; s_tready is low
// from accept until its result is loaded into the output register. Schedule
// and take walk all SLOTS slots through the single read port of the slot
// store, one slot per cycle, then pass a drain state and a finish state that
// loads the result into the output register; the next request is accepted
// once the sequencer is back in idle. Status requests and refused schedules
// go straight from accept to the finish state. A result waiting on m_tready
// holds the next result in its final cycle. The enable register is to be
// written through cfg_wr_en / cfg_wr_data only while no request is in flight;
// the block itself does not enforce this. Schedules are refused while it is
// zero, takes are always served.
module coalescing_work_slot_table
    import cwst_pkg::*;
#(
    parameter int SLOTS    = 16,
    parameter int ARG_BITS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,    // enable
    // request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,        // [15:0] handler_id, [47:16] handler_arg
    input  logic [1:0]   s_tuser,        // [1:0] action
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [183:0] m_tdata,        // [15:0] out_handler, [47:16] out_arg,
                                         // [52:48] pending_count, [53] any_pending,
                                         // [85:54] scheduled_total,
                                         // [117:86] coalesced_total,
                                         // [149:118] dropped_total,
                                         // [181:150] taken_total, [183:182] zero
    output logic [2:0]   m_tuser         // [2:0] status
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t               state_reg;
    op_t                  op_reg;
    logic                 enable_reg;
    logic [SLOTS-1:0]     pend_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [TOTAL_W-1:0]   sched_tot_reg;
    logic [TOTAL_W-1:0]   coal_tot_reg;
    logic [TOTAL_W-1:0]   drop_tot_reg;
    logic [TOTAL_W-1:0]   taken_tot_reg;

    logic [HANDLER_W-1:0] req_h_reg;
    logic [ARG_BITS-1:0]  req_arg_reg;
    logic [IDX_W-1:0]     scan_idx_reg;

    logic                 ev_valid_reg;
    logic                 ev_pend_reg;
    logic                 ev_first_reg;

    logic                 match_reg;
    logic                 free_found_reg;
    logic [IDX_W-1:0]     free_idx_reg;
    logic                 take_found_reg;
    logic [IDX_W-1:0]     take_idx_reg;
    logic [HANDLER_W-1:0] take_h_reg;
    logic [ARG_BITS-1:0]  take_arg_reg;

    logic                 m_valid_reg;
    logic [2:0]           res_status_reg;
    logic [HANDLER_W-1:0] res_h_reg;
    logic [TAG_W-1:0]     res_arg_reg;

    logic [HANDLER_W-1:0] rd_handler;
    logic [ARG_BITS-1:0]  rd_arg;

    logic                 in_beat;
    logic                 out_free;
    logic                 finish_go;
    logic                 mem_wr_en;
    logic                 hit;
    logic [2:0]           status_next;
    logic [ARG_BITS-1:0]  in_arg;
    logic [TAG_W-1:0]     take_arg_out;
    logic [CNT_W+4:0]     cnt_wide;
    logic [COUNT_W-1:0]   cnt_sat;

    assign in_beat   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign out_free  = !m_valid_reg || m_tready;
    assign finish_go = (state_reg == S_FINISH) && out_free;

    // Fit the argument tag to the stored width and back
    if (ARG_BITS > TAG_W) begin : g_arg_wide
        assign in_arg       = {{(ARG_BITS-TAG_W){1'b0}}, s_tdata[47:16]};
        assign take_arg_out = take_arg_reg[TAG_W-1:0];
    end else if (ARG_BITS == TAG_W) begin : g_arg_same
        assign in_arg       = s_tdata[47:16];
        assign take_arg_out = take_arg_reg;
    end else begin : g_arg_narrow
        assign in_arg       = s_tdata[16 +: ARG_BITS];
        assign take_arg_out = {{(TAG_W-ARG_BITS){1'b0}}, take_arg_reg};
    end

    // ------------------------------------------------------------------
    // Slot store
    // ------------------------------------------------------------------
    assign mem_wr_en = finish_go && (op_reg == OP_SCHED) && !match_reg && free_found_reg;

    cwst_slot_mem #(
        .SLOTS    (SLOTS),
        .ARG_BITS (ARG_BITS),
        .IDX_W    (IDX_W)
    ) u_slot_mem (
        .aclk       (aclk),
        .wr_en      (mem_wr_en),
        .wr_addr    (free_idx_reg),
        .wr_handler (req_h_reg),
        .wr_arg     (req_arg_reg),
        .rd_addr    (scan_idx_reg),
        .rd_handler (rd_handler),
        .rd_arg     (rd_arg)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (in_beat) begin
                        if (s_tuser == ACT_SCHEDULE) begin
                            if (enable_reg && (s_tdata[15:0] != '0)) begin
                                state_reg <= S_SCAN;
                            end else begin
                                state_reg <= S_FINISH;
                            end
                        end else if (s_tuser == ACT_TAKE) begin
                            state_reg <= S_SCAN;
                        end else begin
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_SCAN: begin
                    if (scan_idx_reg == LAST_IDX) begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    state_reg <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Latch the request
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            req_h_reg   <= s_tdata[15:0];
            req_arg_reg <= in_arg;
            if (s_tuser == ACT_SCHEDULE) begin
                op_reg <= (enable_reg && (s_tdata[15:0] != '0)) ? OP_SCHED : OP_REFUSE;
            end else if (s_tuser == ACT_TAKE) begin
                op_reg <= OP_TAKE;
            end else begin
                op_reg <= OP_STAT;
            end
        end
    end

    // Advance the scan address, one slot per cycle
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE) begin
            scan_idx_reg <= '0;
        end else if (state_reg == S_SCAN && scan_idx_reg != LAST_IDX) begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
    end

    // Issue stage: track lowest free and lowest pending slot
    always_ff @(posedge aclk) begin
        ev_valid_reg <= (state_reg == S_SCAN);
        ev_pend_reg  <= pend_reg[scan_idx_reg];
        ev_first_reg <= pend_reg[scan_idx_reg] && !take_found_reg;
        if (state_reg == S_IDLE) begin
            free_found_reg <= 1'b0;
            take_found_reg <= 1'b0;
        end else if (state_reg == S_SCAN) begin
            if (!pend_reg[scan_idx_reg] && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= scan_idx_reg;
            end
            if (pend_reg[scan_idx_reg] && !take_found_reg) begin
                take_found_reg <= 1'b1;
                take_idx_reg   <= scan_idx_reg;
            end
        end
    end

    // Compare stage: check the returned slot against the request
    assign hit = ev_valid_reg && ev_pend_reg && (rd_handler == req_h_reg)
                 && (rd_arg == req_arg_reg);

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE) begin
            match_reg <= 1'b0;
        end else if (hit) begin
            match_reg <= 1'b1;
        end
        if (ev_valid_reg && ev_first_reg) begin
            take_h_reg   <= rd_handler;
            take_arg_reg <= rd_arg;
        end
    end

    // ------------------------------------------------------------------
    // Finish: commit slot and counter updates, load the result
    // ------------------------------------------------------------------
    always_comb begin
        case (op_reg)
            OP_SCHED: begin
                if (match_reg) begin
                    status_next = RES_COALESCED;
                end else if (free_found_reg) begin
                    status_next = RES_SCHEDULED;
                end else begin
                    status_next = RES_DROPPED;
                end
            end
            OP_TAKE:   status_next = take_found_reg ? RES_TAKEN : RES_EMPTY;
            OP_REFUSE: status_next = RES_REFUSED;
            default:   status_next = RES_STATUS;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= 1'b0;
            pend_reg      <= '0;
            cnt_reg       <= '0;
            sched_tot_reg <= '0;
            coal_tot_reg  <= '0;
            drop_tot_reg  <= '0;
            taken_tot_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                enable_reg <= cfg_wr_data;
            end
            if (finish_go) begin
                case (status_next)
                    RES_SCHEDULED: begin
                        pend_reg[free_idx_reg] <= 1'b1;
                        cnt_reg       <= cnt_reg + 1'b1;
                        sched_tot_reg <= sched_tot_reg + 1'b1;
                    end
                    RES_COALESCED: coal_tot_reg <= coal_tot_reg + 1'b1;
                    RES_DROPPED:   drop_tot_reg <= drop_tot_reg + 1'b1;
                    RES_TAKEN: begin
                        pend_reg[take_idx_reg] <= 1'b0;
                        cnt_reg       <= cnt_reg - 1'b1;
                        taken_tot_reg <= taken_tot_reg + 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (finish_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish_go) begin
            res_status_reg <= status_next;
            if (status_next == RES_TAKEN) begin
                res_h_reg   <= take_h_reg;
                res_arg_reg <= take_arg_out;
            end else begin
                res_h_reg   <= '0;
                res_arg_reg <= '0;
            end
        end
    end

    // Saturate the pending count to the field
    assign cnt_wide = {5'b0, cnt_reg};
    assign cnt_sat  = (cnt_wide > (CNT_W+5)'(COUNT_MAX)) ? COUNT_MAX : cnt_wide[COUNT_W-1:0];

    // Counters only move when a result is loaded, so they are read live
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_status_reg;
    assign m_tdata  = {2'b00, taken_tot_reg, drop_tot_reg, coal_tot_reg, sched_tot_reg,
                       (cnt_reg != '0), cnt_sat, res_arg_reg, res_h_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_matches_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == CNT_W'($countones(pend_reg)))
        else $error("pending count out of step with pending bits");

    a_take_bumps_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (finish_go && status_next == RES_TAKEN) |=> (taken_tot_reg == $past(taken_tot_reg) + 1'b1))
        else $error("taken total not advanced on take");

    a_coalesce_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (finish_go && status_next == RES_COALESCED) |=> $stable(pend_reg))
        else $error("coalesced request changed the pending slots");

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN || state_reg == S_DRAIN) |-> !s_tready)
        else $error("request accepted during a scan");

endmodule

@@ hw/rtl/cwst_slot_mem.sv @@
// ----------------------------------------------------------------------------
// cwst_slot_mem
// Slot store: handler id and argument tag per slot, one write port and one
// registered read port.
// ----------------------------------------------------------------------------
module cwst_slot_mem
    import cwst_pkg::*;
#(
    parameter int SLOTS    = 16,
    parameter int ARG_BITS = 32,
    parameter int IDX_W    = 4
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  logic [HANDLER_W-1:0] wr_handler,
    input  logic [ARG_BITS-1:0]  wr_arg,
    input  logic [IDX_W-1:0]     rd_addr,
    output logic [HANDLER_W-1:0] rd_handler,
    output logic [ARG_BITS-1:0]  rd_arg
);

    logic [HANDLER_W-1:0] handler_mem [SLOTS];
    logic [ARG_BITS-1:0]  arg_mem     [SLOTS];

    // Write one slot
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            handler_mem[wr_addr] <= wr_handler;
            arg_mem[wr_addr]     <= wr_arg;
        end
    end

    // Read one slot, data valid the next cycle
    always_ff @(posedge aclk) begin
        rd_handler <= handler_mem[rd_addr];
        rd_arg     <= arg_mem[rd_addr];
    end

endmodule

@@ sim/tb_coalescing_work_slot_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_coalescing_work_slot_table
// Self-checking bench for the coalescing work slot table.
// ----------------------------------------------------------------------------
// A queue of requests feeds a clocked driver on the request stream. A clocked
// monitor predicts the result of every accepted beat from a private copy of
// the slot table and counters, then compares each result beat field by field
// against the oldest prediction. The run starts with directed requests
// (empty table, refusals, fill, coalesce, drop, lowest-slot reuse), then
// random phases under different enable settings and request mixes. Both
// sides idle in random bursts, and the receiver once holds off for a long
// stretch so the block backs up its input.
module tb_coalescing_work_slot_table
    import cwst_pkg::*;
();

    localparam int SLOT_COUNT   = 16;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 250;
    localparam int HOLD_AT      = 700;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int TAIL_CYCLES  = 2 * SLOT_COUNT + 8;

    // Spare request code, served as a status report
    localparam logic [1:0] ACT_SPARE = 2'd3;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic [HANDLER_W-1:0] handler;
        logic [TAG_W-1:0]     tag;
    } work_request_t;

    typedef struct packed {
        logic [2:0]           status;
        logic [HANDLER_W-1:0] handler;
        logic [TAG_W-1:0]     tag;
        logic [COUNT_W-1:0]   pending;
        logic                 any_busy;
        logic [TOTAL_W-1:0]   sched_total;
        logic [TOTAL_W-1:0]   merged_total;
        logic [TOTAL_W-1:0]   dropped_total;
        logic [TOTAL_W-1:0]   taken_total;
    } work_result_t;

    logic         aclk        = 1'b0;
    logic         aresetn     = 1'b0;
    logic         cfg_wr_en   = 1'b0;
    logic         cfg_wr_data = 1'b0;
    logic         s_tvalid    = 1'b0;
    logic         s_tready;
    logic [47:0]  s_tdata     = '0;     // [15:0] handler_id, [47:16] handler_arg
    logic [1:0]   s_tuser     = '0;     // [1:0] action
    logic         m_tvalid;
    logic         m_tready    = 1'b0;
    logic [183:0] m_tdata;              // [15:0] out_handler, [47:16] out_arg,
                                        // [52:48] pending_count, [53] any_pending,
                                        // [85:54] scheduled_total,
                                        // [117:86] coalesced_total,
                                        // [149:118] dropped_total,
                                        // [181:150] taken_total
    logic [2:0]   m_tuser;              // [2:0] status

    coalescing_work_slot_table dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // Predicted slot table and counters
    logic                 work_enabled;
    logic                 slot_busy    [SLOT_COUNT];
    logic [HANDLER_W-1:0] slot_handler [SLOT_COUNT];
    logic [TAG_W-1:0]     slot_tag     [SLOT_COUNT];
    logic [TOTAL_W-1:0]   sched_count;
    logic [TOTAL_W-1:0]   merged_count;
    logic [TOTAL_W-1:0]   lost_count;
    logic [TOTAL_W-1:0]   taken_count;

    work_request_t request_queue[$];
    work_result_t  expected_results[$];
    work_request_t next_request;

    int  requests_issued   = 0;
    int  requests_accepted = 0;
    int  results_checked   = 0;
    int  mismatches        = 0;
    int  settings_used     = 0;
    int  status_seen[8];
    int  cycle_count       = 0;
    int  send_gap          = 0;
    int  stall_left        = 0;
    int  hold_left         = 0;
    bit  hold_done         = 1'b0;
    bit  quiet             = 1'b0;
    logic s_beat           = 1'b0;

    // Clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Advance the predicted table by one request and return its result
    function automatic work_result_t apply_request(input logic [1:0] kind,
                                                   input logic [HANDLER_W-1:0] hid,
                                                   input logic [TAG_W-1:0] tag);
        work_result_t r;
        int hit;
        int free;
        int n;
        r = '0;
        hit = -1;
        free = -1;
        n = 0;
        if (kind == ACT_SCHEDULE) begin
            if (!work_enabled || hid == '0) begin
                r.status = RES_REFUSED;
            end else begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (hit < 0 && slot_busy[i] && slot_handler[i] == hid &&
                        slot_tag[i] == tag)
                        hit = i;
                    if (free < 0 && !slot_busy[i])
                        free = i;
                end
                if (hit >= 0) begin
                    merged_count = merged_count + 1;
                    r.status = RES_COALESCED;
                end else if (free >= 0) begin
                    slot_busy[free] = 1'b1;
                    slot_handler[free] = hid;
                    slot_tag[free] = tag;
                    sched_count = sched_count + 1;
                    r.status = RES_SCHEDULED;
                end else begin
                    lost_count = lost_count + 1;
                    r.status = RES_DROPPED;
                end
            end
        end else if (kind == ACT_TAKE) begin
            for (int i = 0; i < SLOT_COUNT; i++)
                if (hit < 0 && slot_busy[i])
                    hit = i;
            if (hit >= 0) begin
                r.handler = slot_handler[hit];
                r.tag = slot_tag[hit];
                slot_busy[hit] = 1'b0;
                taken_count = taken_count + 1;
                r.status = RES_TAKEN;
            end else begin
                r.status = RES_EMPTY;
            end
        end else begin
            r.status = RES_STATUS;
        end
        for (int i = 0; i < SLOT_COUNT; i++)
            if (slot_busy[i])
                n++;
        r.pending = (n > COUNT_MAX) ? COUNT_MAX : COUNT_W'(n);
        r.any_busy = (n != 0);
        r.sched_total = sched_count;
        r.merged_total = merged_count;
        r.dropped_total = lost_count;
        r.taken_total = taken_count;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on result %0d: %s got %0h expected %0h",
                 results_checked, what, got, want);
        mismatches++;
    endtask

    // Compare one result beat against the oldest prediction
    task automatic check_result();
        work_result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch("unexpected result, status", m_tuser, '0);
            return;
        end
        want = expected_results.pop_front();
        if (m_tuser !== want.status)
            report_mismatch("status", m_tuser, want.status);
        if (m_tdata[15:0] !== want.handler)
            report_mismatch("out_handler", m_tdata[15:0], want.handler);
        if (m_tdata[47:16] !== want.tag)
            report_mismatch("out_arg", m_tdata[47:16], want.tag);
        if (m_tdata[52:48] !== want.pending)
            report_mismatch("pending_count", m_tdata[52:48], want.pending);
        if (m_tdata[53] !== want.any_busy)
            report_mismatch("any_pending", m_tdata[53], want.any_busy);
        if (m_tdata[85:54] !== want.sched_total)
            report_mismatch("scheduled_total", m_tdata[85:54], want.sched_total);
        if (m_tdata[117:86] !== want.merged_total)
            report_mismatch("coalesced_total", m_tdata[117:86], want.merged_total);
        if (m_tdata[149:118] !== want.dropped_total)
            report_mismatch("dropped_total", m_tdata[149:118], want.dropped_total);
        if (m_tdata[181:150] !== want.taken_total)
            report_mismatch("taken_total", m_tdata[181:150], want.taken_total);
        status_seen[m_tuser]++;
        results_checked++;
    endtask

    // Monitor: check result beats, then predict accepted request beats
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_beat <= 1'b0;
        end else begin
            s_beat <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_request(s_tuser, s_tdata[15:0],
                                                         s_tdata[47:16]));
                requests_accepted++;
            end
        end
    end

    // Driver: hold the beat until accepted, idle in bursts, else send the next
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_beat) begin
            // hold the current beat
        end else if (send_gap > 0) begin
            send_gap = send_gap - 1;
            s_tvalid <= 1'b0;
        end else if (request_queue.size() == 0) begin
            s_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            send_gap = $urandom_range(1, 9) - 1;
            s_tvalid <= 1'b0;
        end else begin
            next_request = request_queue.pop_front();
            s_tvalid <= 1'b1;
            s_tuser <= next_request.kind;
            s_tdata <= {next_request.tag, next_request.handler};
        end
    end

    // Receiver: one long hold-off, random stall bursts, none when quiet
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (!hold_done && results_checked >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic queue_request(input logic [1:0] kind, input logic [HANDLER_W-1:0] hid,
                                 input logic [TAG_W-1:0] tag);
        work_request_t q;
        q.kind = kind;
        q.handler = hid;
        q.tag = tag;
        request_queue.push_back(q);
        requests_issued++;
    endtask

    // Write the enable register while nothing is in flight
    task automatic write_enable(input logic value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        work_enabled = value;
        settings_used++;
    endtask

    // Wait until every request is accepted and every result has arrived
    task automatic wait_idle();
        while (requests_accepted != requests_issued || expected_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Random request: small handler and tag pools make duplicates common
    task automatic queue_random(input mix_t mix);
        int pick;
        int sched_pct;
        int take_pct;
        logic [1:0] kind;
        logic [HANDLER_W-1:0] hid;
        logic [TAG_W-1:0] tag;
        sched_pct = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 30 : 50;
        take_pct = (mix == MIX_FILL) ? 20 : (mix == MIX_DRAIN) ? 60 : 40;
        pick = $urandom_range(0, 99);
        if (pick < sched_pct)
            kind = ACT_SCHEDULE;
        else if (pick < sched_pct + take_pct)
            kind = ACT_TAKE;
        else
            kind = $urandom_range(0, 1) ? ACT_STATUS : ACT_SPARE;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            hid = '0;
            tag = $urandom();
        end else if (pick < 70) begin
            hid = HANDLER_W'($urandom_range(1, 4));
            tag = TAG_W'($urandom_range(0, 3));
        end else begin
            hid = HANDLER_W'($urandom());
            tag = $urandom();
        end
        queue_request(kind, hid, tag);
    endtask

    initial begin
        work_enabled = 1'b0;
        sched_count = '0;
        merged_count = '0;
        lost_count = '0;
        taken_count = '0;
        foreach (slot_busy[i]) begin
            slot_busy[i] = 1'b0;
            slot_handler[i] = '0;
            slot_tag[i] = '0;
        end
        foreach (status_seen[i])
            status_seen[i] = 0;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // Disabled: status, take from empty, refused schedule, spare code
        write_enable(1'b0);
        queue_request(ACT_STATUS, '0, '0);
        queue_request(ACT_TAKE, '0, '0);
        queue_request(ACT_SCHEDULE, 16'hFFFF, 32'hFFFF_FFFF);
        queue_request(ACT_SPARE, 16'hFFFF, 32'hFFFF_FFFF);
        wait_idle();

        // Enabled: null handler, fill, coalesce, drop, reuse of lowest slot
        write_enable(1'b1);
        queue_request(ACT_SCHEDULE, '0, 32'h1234_5678);
        queue_request(ACT_SCHEDULE, 16'h0001, '0);
        queue_request(ACT_SCHEDULE, 16'h0001, '0);
        queue_request(ACT_SCHEDULE, 16'hFFFF, 32'hFFFF_FFFF);
        queue_request(ACT_SCHEDULE, 16'h0001, 32'h0000_0001);
        for (int i = 3; i < SLOT_COUNT; i++)
            queue_request(ACT_SCHEDULE, HANDLER_W'(16'h0100 + i), 32'hA5A5_0000 + i);
        queue_request(ACT_SCHEDULE, 16'h7777, 32'h5A5A_5A5A);
        queue_request(ACT_SCHEDULE, 16'hFFFF, 32'hFFFF_FFFF);
        queue_request(ACT_TAKE, '0, '0);
        queue_request(ACT_SCHEDULE, 16'h8000, 32'h8000_0000);
        queue_request(ACT_STATUS, '0, '0);
        wait_idle();

        // Random phases; disabled ones exercise take without enable
        for (int p = 0; p < PHASES; p++) begin
            write_enable((p == 2 || p == 5) ? 1'b0 : 1'b1);
            quiet = (p == PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
                queue_random(mix_t'(p % 3));
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("summary: %0d requests, %0d results checked, %0d enable writes",
                 requests_issued, results_checked, settings_used);
        $display("summary: sched %0d merged %0d dropped %0d refused %0d taken %0d empty %0d",
                 status_seen[RES_SCHEDULED], status_seen[RES_COALESCED],
                 status_seen[RES_DROPPED], status_seen[RES_REFUSED],
                 status_seen[RES_TAKEN], status_seen[RES_EMPTY]);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ coalescing_work_slot_table.f @@
hw/rtl/cwst_pkg.sv
hw/rtl/cwst_slot_mem.sv
hw/rtl/coalescing_work_slot_table.sv
sim/tb_coalescing_work_slot_table.sv
